@@ rtl/core/swsnd_pkg.sv @@
// Shared constants, codes and control/status types of the sliding window sender.
`default_nettype none
package swsnd_pkg;

	// Field widths
	localparam int FRAME_W    = 8;
	localparam int NEXT_W     = 9;
	localparam int CNT_W      = 4;
	localparam int WIN_W      = 4;
	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Most results one event can produce
	localparam int MAX_SENDS = 8;

	// Highest frame number ever sent
	localparam int FRAME_LIMIT = 255;

	// Default window store depth
	localparam int WINDOW_DEPTH_DEF = 8;

	// Register reset values
	localparam logic [FRAME_W-1:0] TOTAL_RST  = 8'd0;
	localparam logic [WIN_W-1:0]   WINDOW_RST = 4'd8;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NAK   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL_FRAMES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_IN_USE = 2'd1;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_REMOVE,
		ST_ACK_SETUP,
		ST_SEND,
		ST_NAK_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic start_init;
		logic idx_clr;
		logic idx_inc;
		logic rd_en;
		logic rd_next;
		logic shift_wr;
		logic count_dec;
		logic pend_inc;
		logic mark_pos;
		logic ack_setup;
		logic send;
		logic nak_out;
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic             count_zero;
		logic             hit;
		logic             idx_last;
		logic             pos_zero;
		logic             send_ok;
		logic             send_last;
		logic             out_free;
	} sts_t;

endpackage
`default_nettype wire

@@ rtl/core/swsnd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swsnd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/swsnd_ctrl.sv @@
// Controller state machine: sequences search, compaction and sends per event.
`default_nettype none
module swsnd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire swsnd_pkg::sts_t sts,
	output swsnd_pkg::ctl_t    ctl
);
	import swsnd_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		ctl      = '0;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_d    = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.cmd)
					CMD_START: begin
						ctl.start_init = 1'b1;
						state_d        = ST_SEND;
					end
					CMD_ACK, CMD_NAK: begin
						ctl.idx_clr = 1'b1;
						state_d     = sts.count_zero ? ST_IDLE : ST_SRCH_RD;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			// each window entry is read, then compared
			ST_SRCH_RD: begin
				ctl.rd_en = 1'b1;
				state_d   = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (sts.hit) begin
					if (sts.cmd == CMD_NAK) begin
						state_d = ST_NAK_OUT;
					end else begin
						ctl.mark_pos = 1'b1;
						state_d      = ST_SHIFT_RD;
					end
				end else if (sts.idx_last) begin
					state_d = ST_IDLE;
				end else begin
					ctl.idx_inc = 1'b1;
					state_d     = ST_SRCH_RD;
				end
			end
			// close the gap: move each later entry down by one
			ST_SHIFT_RD: begin
				if (sts.idx_last) begin
					state_d = ST_REMOVE;
				end else begin
					ctl.rd_en   = 1'b1;
					ctl.rd_next = 1'b1;
					state_d     = ST_SHIFT_WR;
				end
			end
			ST_SHIFT_WR: begin
				ctl.shift_wr = 1'b1;
				state_d      = ST_SHIFT_RD;
			end
			ST_REMOVE: begin
				ctl.count_dec = 1'b1;
				if (sts.pos_zero) begin
					state_d = ST_ACK_SETUP;
				end else begin
					ctl.pend_inc = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			ST_ACK_SETUP: begin
				ctl.ack_setup = 1'b1;
				state_d       = ST_SEND;
			end
			// one new frame per cycle while the output slot is free
			ST_SEND: begin
				if (!sts.send_ok) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					ctl.send = 1'b1;
					if (sts.send_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_NAK_OUT: begin
				if (sts.out_free) begin
					ctl.nak_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/swsnd_dp.sv @@
// Datapath: configuration, window store, counters and output register.
`default_nettype none
module swsnd_dp #(
	parameter int WINDOW_DEPTH = swsnd_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration
	input  wire logic                             cfg_we,
	input  wire logic [swsnd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swsnd_pkg::CFG_DATA_W-1:0] cfg_data,
	// input payload
	input  wire logic [swsnd_pkg::CMD_W-1:0]      cmd,
	input  wire logic [swsnd_pkg::FRAME_W-1:0]    frame_number,
	// output channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [swsnd_pkg::FRAME_W-1:0]    send_frame,
	output logic                                  is_resend,
	output logic                                  last,
	// controller link
	input  wire swsnd_pkg::ctl_t                  ctl,
	output swsnd_pkg::sts_t                       sts
);
	import swsnd_pkg::*;

	localparam int AW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WCAP = (WINDOW_DEPTH < MAX_SENDS) ? WINDOW_DEPTH : MAX_SENDS;
	localparam int TCAP = (FRAME_LIMIT < 255) ? FRAME_LIMIT : 255;
	localparam logic [WIN_W-1:0]  WIN_CAP   = WIN_W'(WCAP);
	localparam logic [NEXT_W-1:0] TOTAL_CAP = NEXT_W'(TCAP);

	logic [FRAME_W-1:0] total_q;
	logic [WIN_W-1:0]   win_q;
	logic [CMD_W-1:0]   cmd_q;
	logic [FRAME_W-1:0] num_q;
	logic [CNT_W-1:0]   count_q;
	logic [NEXT_W-1:0]  next_q;
	logic [CNT_W-1:0]   pending_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   limit_q;
	logic               pos0_q;
	logic               out_valid_q;
	logic [FRAME_W-1:0] send_frame_q;
	logic               is_resend_q;
	logic               last_q;

	logic [WIN_W-1:0]   eff_win;
	logic [NEXT_W-1:0]  eff_total;
	logic [CNT_W:0]     pend_plus;
	logic [CNT_W-1:0]   ack_limit;
	logic [CNT_W-1:0]   idx_next;
	logic               out_free;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [FRAME_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [FRAME_W-1:0] ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= TOTAL_RST;
			win_q   <= WINDOW_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_TOTAL_FRAMES) begin
				total_q <= cfg_data;
			end else if (cfg_index == REG_WINDOW_IN_USE) begin
				win_q <= cfg_data[WIN_W-1:0];
			end
		end
	end

	// Effective window and frame total
	always_comb begin
		if (win_q == '0) begin
			eff_win = WIN_W'(1);
		end else if (win_q > WIN_CAP) begin
			eff_win = WIN_CAP;
		end else begin
			eff_win = win_q;
		end
		eff_total = ({1'b0, total_q} > TOTAL_CAP) ? TOTAL_CAP : {1'b0, total_q};
	end

	// New frames allowed after an in-order ACK
	always_comb begin
		pend_plus = {1'b0, pending_q} + (CNT_W+1)'(1);
		if (count_q >= eff_win) begin
			ack_limit = '0;
		end else if (pend_plus > (CNT_W+1)'(MAX_SENDS)) begin
			ack_limit = CNT_W'(MAX_SENDS);
		end else begin
			ack_limit = pend_plus[CNT_W-1:0];
		end
	end

	assign idx_next = idx_q + CNT_W'(1);
	assign out_free = !out_valid_q || !out_stall;

	// Latched item
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= cmd;
			num_q <= frame_number;
		end
	end

	// Window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_q    <= NEXT_W'(1);
			pending_q <= '0;
			idx_q     <= '0;
			k_q       <= '0;
			limit_q   <= '0;
			pos0_q    <= 1'b0;
		end else begin
			if (ctl.start_init) begin
				count_q   <= '0;
				next_q    <= NEXT_W'(1);
				pending_q <= '0;
				k_q       <= '0;
				limit_q   <= eff_win;
			end
			if (ctl.idx_clr) begin
				idx_q <= '0;
			end
			if (ctl.idx_inc || ctl.shift_wr) begin
				idx_q <= idx_next;
			end
			if (ctl.mark_pos) begin
				pos0_q <= (idx_q == '0);
			end
			if (ctl.count_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (ctl.pend_inc && (pending_q != '1)) begin
				pending_q <= pending_q + CNT_W'(1);
			end
			if (ctl.ack_setup) begin
				limit_q   <= ack_limit;
				pending_q <= '0;
				k_q       <= '0;
			end
			if (ctl.send) begin
				count_q <= count_q + CNT_W'(1);
				next_q  <= next_q + NEXT_W'(1);
				k_q     <= k_q + CNT_W'(1);
			end
		end
	end

	// Window store ports
	always_comb begin
		ram_we    = ctl.send || ctl.shift_wr;
		ram_waddr = ctl.send ? AW'(count_q) : AW'(idx_q);
		ram_wdata = ctl.send ? next_q[FRAME_W-1:0] : ram_rdata;
		ram_raddr = ctl.rd_next ? AW'(idx_next) : AW'(idx_q);
	end

	swsnd_ram #(
		.WIDTH (FRAME_W),
		.DEPTH (WINDOW_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ctl.rd_en),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.send || ctl.nak_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.send) begin
			send_frame_q <= next_q[FRAME_W-1:0];
			is_resend_q  <= 1'b0;
			last_q       <= sts.send_last;
		end else if (ctl.nak_out) begin
			send_frame_q <= num_q;
			is_resend_q  <= 1'b1;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign send_frame = send_frame_q;
	assign is_resend  = is_resend_q;
	assign last       = last_q;

	// Status to controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.count_zero = (count_q == '0);
		sts.hit        = (ram_rdata == num_q);
		sts.idx_last   = ({1'b0, idx_q} + (CNT_W+1)'(1)) >= {1'b0, count_q};
		sts.pos_zero   = pos0_q;
		sts.send_ok    = (k_q < limit_q) && (next_q <= eff_total) && (count_q < eff_win);
		sts.send_last  = (({1'b0, k_q} + (CNT_W+1)'(1)) >= {1'b0, limit_q})
			|| (({1'b0, next_q} + (NEXT_W+1)'(1)) > {1'b0, eff_total})
			|| (({1'b0, count_q} + (CNT_W+1)'(1)) >= {1'b0, eff_win});
		sts.out_free   = out_free;
	end

endmodule
`default_nettype wire

@@ rtl/core/sliding_window_sender_core.sv @@
// Top level of the sliding window sender: controller plus datapath.
//
// Sender side of a selective-repeat link, tracking frame numbers only.
// Input channel (in_valid/in_stall) takes one event per transfer: cmd
// start, ACK or NAK, with frame_number for ACK/NAK. Output channel
// (out_valid/out_stall) gives frames to transmit, new ones or resends,
// with last set on the final transfer of each event; an event may give
// no transfer at all.
// Configuration (cfg_valid/cfg_ready) writes total_frames (index 0) and
// window_in_use (index 1); cfg_ready is always high. Write only while idle.
// One event at a time: in_stall is high from acceptance until its work ends.
// A start sends its new frames one by one. An ACK or NAK searches the window
// store entry by entry (single read port of the window store); an ACK hit
// then moves each later entry down, an in-order ACK also sends new frames,
// and a NAK hit gives one resend. A stalled receiver holds the output
// register and pauses sending.
// Reset clears all counters, sets frame 1 as next, window_in_use to 8 and
// total_frames to 0; the window store needs no clearing.
`default_nettype none
module sliding_window_sender_core #(
	parameter int WINDOW_DEPTH = swsnd_pkg::WINDOW_DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// event channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [swsnd_pkg::CMD_W-1:0]      cmd,
	input  wire logic [swsnd_pkg::FRAME_W-1:0]    frame_number,
	// frame channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic      [swsnd_pkg::FRAME_W-1:0]    send_frame,
	output logic                                  is_resend,
	output logic                                  last,
	// configuration channel
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [swsnd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swsnd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import swsnd_pkg::*;

	ctl_t ctl;
	sts_t sts;

	assign cfg_ready = 1'b1;

	// Sequencer
	swsnd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.ctl      (ctl)
	);

	// Storage and arithmetic
	swsnd_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.send_frame   (send_frame),
		.is_resend    (is_resend),
		.last         (last),
		.ctl          (ctl),
		.sts          (sts)
	);

endmodule
`default_nettype wire

@@ bench/sliding_window_sender_checker.sv @@
// Checker for the sliding window sender: tracks the window, predicts frame transfers, compares.
module sliding_window_sender_checker (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	input  wire logic                             in_stall,
	input  wire logic [swsnd_pkg::CMD_W-1:0]      cmd,
	input  wire logic [swsnd_pkg::FRAME_W-1:0]    frame_number,
	input  wire logic                             out_valid,
	input  wire logic                             out_stall,
	input  wire logic [swsnd_pkg::FRAME_W-1:0]    send_frame,
	input  wire logic                             is_resend,
	input  wire logic                             last,
	input  wire logic                             cfg_valid,
	input  wire logic                             cfg_ready,
	input  wire logic [swsnd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [swsnd_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                                    mismatch_count,
	output int                                    owed_count
);
	import swsnd_pkg::*;

	// Cap on printed mismatch lines; counting goes on past it
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		logic               resend;
		logic               last;
	} frame_xfer_t;

	frame_xfer_t owed_q[$];
	frame_xfer_t want;

	// Shadow registers and window state
	logic [FRAME_W-1:0] total_reg  = TOTAL_RST;
	logic [WIN_W-1:0]   window_reg = WINDOW_RST;
	logic [FRAME_W-1:0] outstanding[WINDOW_DEPTH_DEF];
	int                 out_cnt    = 0;
	logic [NEXT_W-1:0]  next_frame = NEXT_W'(1);
	int                 pend_acks  = 0;

	// Transfers produced by the event being predicted
	logic [FRAME_W-1:0] batch_frame[MAX_SENDS];
	logic               batch_resend[MAX_SENDS];
	int                 batch_n;

	task automatic report(input string what, input int want_val, input int got_val);
		if (mismatch_count < PRINT_CAP)
			$display("ERROR %0t: %s: expected %0d, got %0d", $time, what, want_val, got_val);
		mismatch_count++;
	endtask

	// Window register clamped to 1..min(depth, most sends per event)
	function automatic int window_limit();
		int w;
		w = int'(window_reg);
		if (w < 1) w = 1;
		if (w > WINDOW_DEPTH_DEF) w = WINDOW_DEPTH_DEF;
		if (w > MAX_SENDS) w = MAX_SENDS;
		return w;
	endfunction

	function automatic int frame_total();
		int t;
		t = int'(total_reg);
		if (t > FRAME_LIMIT) t = FRAME_LIMIT;
		return t;
	endfunction

	// Position of a frame in the window, oldest first; -1 if not outstanding
	function automatic int find_frame(input logic [FRAME_W-1:0] fn);
		int pos;
		pos = -1;
		for (int j = out_cnt - 1; j >= 0; j--)
			if (outstanding[j] == fn) pos = j;
		return pos;
	endfunction

	task automatic drop_at(input int pos);
		for (int j = pos; j + 1 < out_cnt; j++)
			outstanding[j] = outstanding[j + 1];
		if (out_cnt > 0) out_cnt--;
	endtask

	// New frames while budget, frames left and window room allow
	task automatic send_fresh(input int budget);
		int w;
		int t;
		w = window_limit();
		t = frame_total();
		while (batch_n < budget && int'(next_frame) <= t && out_cnt < w) begin
			outstanding[out_cnt] = next_frame[FRAME_W-1:0];
			out_cnt++;
			batch_frame[batch_n] = next_frame[FRAME_W-1:0];
			batch_resend[batch_n] = 1'b0;
			batch_n++;
			next_frame = next_frame + 1'b1;
		end
	endtask

	task automatic predict_event(input logic [CMD_W-1:0] c, input logic [FRAME_W-1:0] fn);
		int pos;
		int budget;
		batch_n = 0;
		case (c)
		CMD_START: begin
			out_cnt = 0;
			pend_acks = 0;
			next_frame = NEXT_W'(1);
			send_fresh(window_limit());
		end
		CMD_ACK: begin
			pos = find_frame(fn);
			if (pos == 0) begin
				// in-order ACK: slide and refill
				drop_at(0);
				budget = pend_acks + 1;
				if (budget > MAX_SENDS) budget = MAX_SENDS;
				if (out_cnt >= window_limit()) budget = 0;
				send_fresh(budget);
				pend_acks = 0;
			end else if (pos > 0) begin
				drop_at(pos);
				if (pend_acks < 15) pend_acks++;
			end
		end
		CMD_NAK: begin
			pos = find_frame(fn);
			if (pos >= 0) begin
				batch_frame[0] = outstanding[pos];
				batch_resend[0] = 1'b1;
				batch_n = 1;
			end
		end
		default: ;
		endcase
		for (int i = 0; i < batch_n; i++)
			owed_q.insert(owed_q.size(), {batch_frame[i], batch_resend[i], i == batch_n - 1});
	endtask

	// Config writes, then event acceptance, then frame transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_reg = TOTAL_RST;
			window_reg = WINDOW_RST;
			out_cnt = 0;
			next_frame = NEXT_W'(1);
			pend_acks = 0;
			owed_q.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_TOTAL_FRAMES) total_reg = cfg_data[FRAME_W-1:0];
				else if (cfg_index == REG_WINDOW_IN_USE) window_reg = cfg_data[WIN_W-1:0];
			end
			if (in_valid && !in_stall) predict_event(cmd, frame_number);
			if (out_valid && !out_stall) begin
				if (owed_q.size() == 0) begin
					report("frame transfer with nothing owed", -1, int'(send_frame));
				end else begin
					want = owed_q.pop_front();
					if (send_frame !== want.frame)
						report("send_frame", int'(want.frame), int'(send_frame));
					if (is_resend !== want.resend)
						report("is_resend", int'(want.resend), int'(is_resend));
					if (last !== want.last)
						report("last", int'(want.last), int'(last));
				end
			end
		end
		owed_count = owed_q.size();
	end

endmodule

@@ bench/sliding_window_sender_core_tb.sv @@
// Testbench top for the sliding window sender: clock, reset, stimulus, stalls and verdict.
module sliding_window_sender_core_tb;
	import swsnd_pkg::*;

	localparam logic [CMD_W-1:0]     CMD_NONE  = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int RANDOM_ITEMS  = 140;
	localparam int SETTLE_CYCLES = 60;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 2000;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  in_valid     = 1'b0;
	logic [CMD_W-1:0]      cmd          = CMD_START;
	logic [FRAME_W-1:0]    frame_number = '0;
	logic                  out_stall    = 1'b0;
	logic                  cfg_valid    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = REG_TOTAL_FRAMES;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	wire logic               in_stall;
	wire logic               out_valid;
	wire logic [FRAME_W-1:0] send_frame;
	wire logic               is_resend;
	wire logic               last;
	wire logic               cfg_ready;

	int mismatch_count;
	int owed_count;

	// No-idle stretches, receiver hold requests, frames seen in flight
	bit                 quiet       = 1'b0;
	int                 hold_asked  = 0;
	int                 hold_taken  = 0;
	bit                 out_took    = 1'b0;
	int                 stall_left  = 0;
	int                 hold_left   = 0;
	int                 idle_cycles = 0;
	logic [FRAME_W-1:0] air[$];

	sliding_window_sender_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.send_frame   (send_frame),
		.is_resend    (is_resend),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	sliding_window_sender_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.frame_number   (frame_number),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.send_frame     (send_frame),
		.is_resend      (is_resend),
		.last           (last),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.owed_count     (owed_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sliding_window_sender_core: mismatch");
			$finish;
		end
	end

	// Track new frames on the wire so ACK/NAK can name live ones
	always @(posedge clk) begin
		out_took = out_valid && !out_stall;
		if (in_valid && !in_stall && cmd == CMD_START) air.delete();
		if (out_valid && !out_stall && !is_resend) air.insert(air.size(), send_frame);
	end

	// Receiver: random wait per frame, plus one long hold on request
	always @(negedge clk) begin
		if (hold_asked != hold_taken) begin
			hold_taken = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (out_took) stall_left = quiet ? 0 : $urandom_range(0, 14);
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// One event transfer; starts and ends at a falling edge, valid left high
	task automatic offer(input logic [CMD_W-1:0] c, input logic [FRAME_W-1:0] fn);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		frame_number <= fn;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// Sender pause until every owed frame is out and the block has settled
	task automatic drain();
		in_valid <= 1'b0;
		while (owed_count != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_regs(input logic [7:0] total, input logic [3:0] win, input bit spare);
		logic [7:0] noise;
		noise = 8'($urandom);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TOTAL_FRAMES;
		cfg_data <= total;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		// upper data bits are don't-care for the window register
		cfg_index <= REG_WINDOW_IN_USE;
		cfg_data <= {noise[7:4], win};
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= ~noise;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int items;
		int phase;
		int phase_len;
		int r;
		int idx;
		logic [7:0] total;
		logic [3:0] win;
		logic [7:0] fn;
		logic [CMD_W-1:0] c;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset config (no frames): everything is ignored or empty
		offer(CMD_ACK, 8'd5);
		offer(CMD_NAK, 8'd0);
		offer(CMD_START, 8'hFF);
		offer(CMD_NONE, 8'hFF);
		drain();

		// Full frame range, window register above depth
		write_regs(8'd255, 4'd15, 1'b1);
		offer(CMD_START, 8'h00);
		offer(CMD_ACK, 8'd3);
		offer(CMD_ACK, 8'd5);
		offer(CMD_NAK, 8'd4);
		offer(CMD_NAK, 8'd8);
		offer(CMD_ACK, 8'd1);
		offer(CMD_ACK, 8'd200);
		offer(CMD_NAK, 8'd255);
		offer(CMD_ACK, 8'd2);
		offer(CMD_START, 8'h55);
		offer(CMD_NAK, 8'd1);
		drain();

		// Window register zero acts as one; run out of frames
		write_regs(8'd3, 4'd0, 1'b0);
		offer(CMD_START, 8'hAA);
		offer(CMD_ACK, 8'd1);
		offer(CMD_NAK, 8'd2);
		offer(CMD_ACK, 8'd2);
		offer(CMD_ACK, 8'd3);
		offer(CMD_NAK, 8'd3);
		drain();

		// Random phases: mostly live ACK/NAK traffic, some restarts and noise
		items = 0;
		phase = 0;
		while (items < RANDOM_ITEMS) begin
			drain();
			r = $urandom_range(0, 9);
			if (r == 0) total = 8'd0;
			else if (r == 1) total = 8'd255;
			else if (r == 2) total = 8'($urandom);
			else total = 8'($urandom_range(1, 40));
			win = 4'($urandom_range(0, 15));
			quiet = ($urandom_range(0, 3) == 0);
			if (phase == 2) begin
				// receiver holds off while events keep coming
				total = 8'd255;
				win = 4'd8;
				quiet = 1'b0;
			end
			write_regs(total, win, 1'b0);
			if (phase == 2) hold_asked++;
			fn = 8'($urandom);
			offer(CMD_START, fn);
			items++;
			phase_len = $urandom_range(15, 30);
			for (int n = 0; n < phase_len && items < RANDOM_ITEMS; n++) begin
				r = $urandom_range(0, 99);
				if (r < 55 && air.size() > 0) begin
					idx = $urandom_range(0, 1) ? 0 : $urandom_range(0, air.size() - 1);
					fn = air[idx];
					air.delete(idx);
					offer(CMD_ACK, fn);
					items++;
				end else if (r < 70 && air.size() > 0) begin
					idx = $urandom_range(0, air.size() - 1);
					offer(CMD_NAK, air[idx]);
					items++;
				end else if (r < 75) begin
					fn = 8'($urandom);
					offer(CMD_START, fn);
					items++;
				end else begin
					c = CMD_W'($urandom_range(0, 3));
					fn = 8'($urandom);
					offer(c, fn);
					items++;
				end
			end
			phase++;
		end

		drain();
		if (mismatch_count == 0)
			$display("sliding_window_sender_core: match");
		else
			$display("sliding_window_sender_core: mismatch");
		$finish;
	end

endmodule
